// File: hdl/cp8_pkg.sv
// Shared types, codes and constant tables for the CHIP-8 instruction core.
// Self-contained; used by cp8_ctrl, cp8_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package cp8_pkg;

    localparam int          CP8_MEM_DEPTH   = 4096;
    localparam int          CP8_FONT_LEN    = 80;
    localparam logic [11:0] CP8_FONT_BASE   = 12'd80;
    localparam logic [11:0] CP8_START_RESET = 12'h200;
    localparam int          CP8_SCR_H       = 32;
    localparam int          CP8_IN_W        = 56;
    localparam int          CP8_OUT_W       = 104;

    // item kinds carried on tuser
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // fault codes
    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_OVER  = 2'd1;
    localparam logic [1:0] FLT_UNDER = 2'd2;

    // opcode groups (top nibble)
    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SE   = 4'h3;
    localparam logic [3:0] GRP_SNE  = 4'h4;
    localparam logic [3:0] GRP_SER  = 4'h5;
    localparam logic [3:0] GRP_LDI  = 4'h6;
    localparam logic [3:0] GRP_ADDI = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;
    localparam logic [3:0] GRP_SNER = 4'h9;
    localparam logic [3:0] GRP_SETI = 4'hA;
    localparam logic [3:0] GRP_JPV0 = 4'hB;
    localparam logic [3:0] GRP_RND  = 4'hC;
    localparam logic [3:0] GRP_DRW  = 4'hD;
    localparam logic [3:0] GRP_KEY  = 4'hE;
    localparam logic [3:0] GRP_MISC = 4'hF;

    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [15:0] INS_RET = 16'h00EE;

    // ALU sub-operations of group 8
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // low bytes of groups E and F
    localparam logic [7:0] KK_SKP   = 8'h9E;
    localparam logic [7:0] KK_SKNP  = 8'hA1;
    localparam logic [7:0] KK_LDDT  = 8'h07;
    localparam logic [7:0] KK_SETDT = 8'h15;
    localparam logic [7:0] KK_SETST = 8'h18;
    localparam logic [7:0] KK_ADDI  = 8'h1E;
    localparam logic [7:0] KK_FONT  = 8'h29;
    localparam logic [7:0] KK_BCD   = 8'h33;
    localparam logic [7:0] KK_STORE = 8'h55;
    localparam logic [7:0] KK_LOAD  = 8'h65;

    localparam logic [7:0] CP8_FONT [CP8_FONT_LEN] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_ACCEPT,
        UOP_FONT,
        UOP_LOAD,
        UOP_FETCH0,
        UOP_FETCH1,
        UOP_FETCH2,
        UOP_RDX,
        UOP_RDY,
        UOP_EXEC,
        UOP_LOOP_RD,
        UOP_LOOP_WR,
        UOP_STORE,
        UOP_RESULT
    } t_uop;

    typedef struct packed {
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] group;
        logic [3:0] nib_n;
        logic [7:0] kk;
        logic       loop_last;
        logic       font_last;
    } t_status;

    // Decimal digit sel (0 hundreds, 1 tens, 2 ones) of an 8-bit value.
    function automatic logic [7:0] cp8_bcd(input logic [7:0] v, input logic [1:0] sel);
        logic [7:0]  hv;
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  t10;
        logic [3:0]  o;
        hv  = (v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0);
        h   = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r   = 7'(v - hv);
        p   = 15'(r) * 15'd205;       // r / 10 for r below 100
        t   = p[14:11];
        t10 = 7'(t) * 7'd10;
        o   = 4'(r - t10);
        case (sel)
            2'd0:    cp8_bcd = {6'b0, h};
            2'd1:    cp8_bcd = {4'b0, t};
            default: cp8_bcd = {4'b0, o};
        endcase
    endfunction

    // Sprite byte placed at column x0 with wraparound; MSB lands at x0.
    function automatic logic [63:0] cp8_sprite_mask(input logic [7:0] bits,
                                                    input logic [5:0] x0);
        logic [63:0]  base;
        logic [127:0] dbl;
        base = '0;
        for (int j = 0; j < 8; j++) begin
            base[j] = bits[7-j];
        end
        dbl = {base, base} << x0;
        cp8_sprite_mask = dbl[127:64];
    endfunction

endpackage
`default_nettype wire

// File: hdl/cp8_ctrl.sv
// Sequencer of the CHIP-8 core: one-hot state machine issuing micro-ops.
// Depends on cp8_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cp8_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire [1:0]        i_in_op,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  cp8_pkg::t_status i_status,
    output cp8_pkg::t_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_INIT    = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_LOAD    = 13'b0000000000100,
        S_FETCH0  = 13'b0000000001000,
        S_FETCH1  = 13'b0000000010000,
        S_FETCH2  = 13'b0000000100000,
        S_RDX     = 13'b0000001000000,
        S_RDY     = 13'b0000010000000,
        S_EXEC    = 13'b0000100000000,
        S_LOOP_RD = 13'b0001000000000,
        S_LOOP_WR = 13'b0010000000000,
        S_STORE   = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_load;

    assign can_load    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd.uop   = cp8_pkg::UOP_IDLE;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                o_cmd.uop = cp8_pkg::UOP_FONT;
                if (i_status.font_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = cp8_pkg::UOP_ACCEPT;
                    case (i_in_op)
                        cp8_pkg::OP_LOAD: n_state = S_LOAD;
                        cp8_pkg::OP_EXEC: n_state = S_FETCH0;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.uop = cp8_pkg::UOP_LOAD;
                n_state   = S_DONE;
            end
            S_FETCH0: begin
                o_cmd.uop = cp8_pkg::UOP_FETCH0;
                n_state   = S_FETCH1;
            end
            S_FETCH1: begin
                o_cmd.uop = cp8_pkg::UOP_FETCH1;
                n_state   = S_FETCH2;
            end
            S_FETCH2: begin
                o_cmd.uop = cp8_pkg::UOP_FETCH2;
                n_state   = S_RDX;
            end
            S_RDX: begin
                o_cmd.uop = cp8_pkg::UOP_RDX;
                n_state   = S_RDY;
            end
            S_RDY: begin
                o_cmd.uop = cp8_pkg::UOP_RDY;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.uop = cp8_pkg::UOP_EXEC;
                if (i_status.group == cp8_pkg::GRP_DRW && i_status.nib_n != 4'd0) begin
                    n_state = S_LOOP_RD;
                end else if (i_status.group == cp8_pkg::GRP_MISC &&
                             i_status.kk == cp8_pkg::KK_LOAD) begin
                    n_state = S_LOOP_RD;
                end else if (i_status.group == cp8_pkg::GRP_MISC &&
                             (i_status.kk == cp8_pkg::KK_STORE ||
                              i_status.kk == cp8_pkg::KK_BCD)) begin
                    n_state = S_STORE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LOOP_RD: begin
                o_cmd.uop = cp8_pkg::UOP_LOOP_RD;
                n_state   = S_LOOP_WR;
            end
            S_LOOP_WR: begin
                o_cmd.uop = cp8_pkg::UOP_LOOP_WR;
                n_state   = i_status.loop_last ? S_DONE : S_LOOP_RD;
            end
            S_STORE: begin
                o_cmd.uop = cp8_pkg::UOP_STORE;
                if (i_status.loop_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (can_load) begin
                    o_cmd.uop   = cp8_pkg::UOP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// File: hdl/cp8_dp.sv
// Datapath of the CHIP-8 core: main memory, registers, stack, timers,
// framebuffer and result register. Depends on cp8_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cp8_dp #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  cp8_pkg::t_cmd                  i_cmd,
    output cp8_pkg::t_status               o_status,
    input  wire [1:0]                      i_in_user,
    input  wire [cp8_pkg::CP8_IN_W-1:0]    i_in_data,
    input  wire                            i_cfg_we,
    input  wire [11:0]                     i_cfg_data,
    output logic [cp8_pkg::CP8_OUT_W-1:0]  o_out_data
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SI_W = $clog2(STACK_DEPTH);

    // main memory
    logic [7:0]  r_mem [cp8_pkg::CP8_MEM_DEPTH];
    logic [7:0]  r_mem_q;
    logic        mem_we;
    logic [11:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;

    logic [11:0] r_pc, n_pc, r_idx, n_idx, r_start;
    logic [15:0] r_instr, n_instr;
    logic [7:0]  r_vx, n_vx, r_vy, n_vy, r_dt, n_dt, r_st, n_st;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [7:0]  r_v [16];
    logic [7:0]  n_v [16];
    logic [11:0] r_stack [STACK_DEPTH];
    logic [11:0] n_stack [STACK_DEPTH];
    logic [63:0] r_fb [cp8_pkg::CP8_SCR_H];
    logic [63:0] n_fb [cp8_pkg::CP8_SCR_H];
    logic [3:0]  r_cnt, n_cnt;
    logic [6:0]  r_font_cnt, n_font_cnt;
    logic [1:0]  r_op, n_op;
    logic [11:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic [4:0]  r_row, n_row;
    logic [15:0] r_keys, n_keys;
    logic [7:0]  r_rnd, n_rnd;
    logic        r_scr, n_scr, r_hit, n_hit;
    logic [1:0]  r_flt, n_flt;
    logic [cp8_pkg::CP8_OUT_W-1:0] r_out, n_out;

    logic [3:0]  grp, fx, fy, fn;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [3:0]  v_ra;
    logic [7:0]  v_rd;
    logic [3:0]  lim;
    logic [11:0] idx_cnt;
    logic [8:0]  sum;
    logic [7:0]  dt_base, st_base;
    logic [SP_W-1:0] sp_dec;
    logic [4:0]  draw_row;
    logic [63:0] draw_mask;
    logic [63:0] row_out;

    assign grp     = r_instr[15:12];
    assign fx      = r_instr[11:8];
    assign fy      = r_instr[7:4];
    assign fn      = r_instr[3:0];
    assign kk      = r_instr[7:0];
    assign nnn     = r_instr[11:0];
    assign idx_cnt = r_idx + {8'b0, r_cnt};
    assign sum     = {1'b0, r_vx} + {1'b0, r_vy};
    assign sp_dec  = r_sp - 1'b1;
    assign draw_row  = r_vy[4:0] + {1'b0, r_cnt};
    assign draw_mask = cp8_pkg::cp8_sprite_mask(r_mem_q, r_vx[5:0]);
    assign row_out   = (r_op == cp8_pkg::OP_READ) ? r_fb[r_row] : 64'b0;

    // single read port on the register file
    always_comb begin
        case (i_cmd.uop)
            cp8_pkg::UOP_RDX:   v_ra = fx;
            cp8_pkg::UOP_RDY:   v_ra = (grp == cp8_pkg::GRP_JPV0) ? 4'd0 : fy;
            default:            v_ra = r_cnt;
        endcase
    end
    assign v_rd = r_v[v_ra];

    // loop bound: rows of a draw, bytes of a block move, digits of BCD
    always_comb begin
        if (grp == cp8_pkg::GRP_DRW) begin
            lim = fn - 4'd1;
        end else if (kk == cp8_pkg::KK_BCD) begin
            lim = 4'd2;
        end else begin
            lim = fx;
        end
    end

    assign o_status.op        = r_op;
    assign o_status.group     = grp;
    assign o_status.nib_n     = fn;
    assign o_status.kk        = kk;
    assign o_status.loop_last = (r_cnt == lim);
    assign o_status.font_last = (r_font_cnt == 7'(cp8_pkg::CP8_FONT_LEN - 1));
    assign o_out_data         = r_out;

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = idx_cnt;
        mem_wd = v_rd;
        mem_ra = idx_cnt;
        case (i_cmd.uop)
            cp8_pkg::UOP_FONT: begin
                mem_we = 1'b1;
                mem_wa = cp8_pkg::CP8_FONT_BASE + {5'b0, r_font_cnt};
                mem_wd = cp8_pkg::CP8_FONT[r_font_cnt];
            end
            cp8_pkg::UOP_LOAD: begin
                mem_we = (r_op == cp8_pkg::OP_LOAD);
                mem_wa = r_addr;
                mem_wd = r_data;
            end
            cp8_pkg::UOP_FETCH0: mem_ra = r_pc;
            cp8_pkg::UOP_FETCH1: mem_ra = r_pc + 12'd1;
            cp8_pkg::UOP_STORE: begin
                mem_we = 1'b1;
                mem_wd = (kk == cp8_pkg::KK_BCD) ? cp8_pkg::cp8_bcd(r_vx, r_cnt[1:0])
                                                 : v_rd;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    always_comb begin
        n_pc = r_pc;  n_idx = r_idx;  n_instr = r_instr;
        n_vx = r_vx;  n_vy = r_vy;    n_dt = r_dt;  n_st = r_st;
        n_sp = r_sp;  n_v = r_v;      n_stack = r_stack;  n_fb = r_fb;
        n_cnt = r_cnt;  n_font_cnt = r_font_cnt;
        n_op = r_op;  n_addr = r_addr;  n_data = r_data;  n_row = r_row;
        n_keys = r_keys;  n_rnd = r_rnd;
        n_scr = r_scr;  n_hit = r_hit;  n_flt = r_flt;  n_out = r_out;
        dt_base = r_dt;  st_base = r_st;
        case (i_cmd.uop)
            cp8_pkg::UOP_ACCEPT: begin
                n_op   = i_in_user;
                n_addr = i_in_data[11:0];
                n_data = i_in_data[19:12];
                n_row  = i_in_data[24:20];
                n_keys = i_in_data[40:25];
                n_rnd  = i_in_data[48:41];
                n_scr  = 1'b0;
                n_hit  = 1'b0;
                n_flt  = cp8_pkg::FLT_NONE;
            end
            cp8_pkg::UOP_FONT:   n_font_cnt = r_font_cnt + 7'd1;
            cp8_pkg::UOP_FETCH1: n_instr[15:8] = r_mem_q;
            cp8_pkg::UOP_FETCH2: begin
                n_instr[7:0] = r_mem_q;
                n_pc         = r_pc + 12'd2;
            end
            cp8_pkg::UOP_RDX: n_vx = v_rd;
            cp8_pkg::UOP_RDY: n_vy = v_rd;
            cp8_pkg::UOP_EXEC: begin
                n_cnt = 4'd0;
                case (grp)
                    cp8_pkg::GRP_SYS: begin
                        if (r_instr == cp8_pkg::INS_CLS) begin
                            for (int i = 0; i < cp8_pkg::CP8_SCR_H; i++) begin
                                n_fb[i] = 64'b0;
                            end
                            n_scr = 1'b1;
                        end else if (r_instr == cp8_pkg::INS_RET) begin
                            if (r_sp == '0) begin
                                n_flt = cp8_pkg::FLT_UNDER;
                            end else begin
                                n_sp = sp_dec;
                                n_pc = r_stack[sp_dec[SI_W-1:0]];
                            end
                        end
                    end
                    cp8_pkg::GRP_JP: n_pc = nnn;
                    cp8_pkg::GRP_CALL: begin
                        if (r_sp >= SP_W'(STACK_DEPTH)) begin
                            n_flt = cp8_pkg::FLT_OVER;
                        end else begin
                            n_stack[r_sp[SI_W-1:0]] = r_pc;
                            n_sp = r_sp + 1'b1;
                            n_pc = nnn;
                        end
                    end
                    cp8_pkg::GRP_SE:   if (r_vx == kk)   n_pc = r_pc + 12'd2;
                    cp8_pkg::GRP_SNE:  if (r_vx != kk)   n_pc = r_pc + 12'd2;
                    cp8_pkg::GRP_SER:  if (r_vx == r_vy) n_pc = r_pc + 12'd2;
                    cp8_pkg::GRP_SNER: if (r_vx != r_vy) n_pc = r_pc + 12'd2;
                    cp8_pkg::GRP_LDI:  n_v[fx] = kk;
                    cp8_pkg::GRP_ADDI: n_v[fx] = r_vx + kk;
                    cp8_pkg::GRP_ALU: begin
                        // Vx first, then VF, so the flag wins for x = F
                        case (fn)
                            cp8_pkg::ALU_MOV: n_v[fx] = r_vy;
                            cp8_pkg::ALU_OR:  n_v[fx] = r_vx | r_vy;
                            cp8_pkg::ALU_AND: n_v[fx] = r_vx & r_vy;
                            cp8_pkg::ALU_XOR: n_v[fx] = r_vx ^ r_vy;
                            cp8_pkg::ALU_ADD: begin
                                n_v[fx] = sum[7:0];
                                n_v[15] = {7'b0, sum[8]};
                            end
                            cp8_pkg::ALU_SUB: begin
                                n_v[fx] = r_vx - r_vy;
                                n_v[15] = {7'b0, (r_vx >= r_vy)};
                            end
                            cp8_pkg::ALU_SHR: begin
                                n_v[fx] = {1'b0, r_vx[7:1]};
                                n_v[15] = {7'b0, r_vx[0]};
                            end
                            cp8_pkg::ALU_SUBN: begin
                                n_v[fx] = r_vy - r_vx;
                                n_v[15] = {7'b0, (r_vy >= r_vx)};
                            end
                            cp8_pkg::ALU_SHL: begin
                                n_v[fx] = {r_vx[6:0], 1'b0};
                                n_v[15] = {7'b0, r_vx[7]};
                            end
                            default: n_v[fx] = r_v[fx];
                        endcase
                    end
                    cp8_pkg::GRP_SETI: n_idx = nnn;
                    cp8_pkg::GRP_JPV0: n_pc = nnn + {4'b0, r_vy};
                    cp8_pkg::GRP_RND:  n_v[fx] = r_rnd & kk;
                    cp8_pkg::GRP_DRW: begin
                        n_scr = 1'b1;
                        n_hit = 1'b0;
                        if (fn == 4'd0) begin
                            n_v[15] = 8'd0;
                        end
                    end
                    cp8_pkg::GRP_KEY: begin
                        if (kk == cp8_pkg::KK_SKP && r_keys[r_vx[3:0]]) begin
                            n_pc = r_pc + 12'd2;
                        end else if (kk == cp8_pkg::KK_SKNP && !r_keys[r_vx[3:0]]) begin
                            n_pc = r_pc + 12'd2;
                        end
                    end
                    default: begin
                        case (kk)
                            cp8_pkg::KK_LDDT:  n_v[fx] = r_dt;
                            cp8_pkg::KK_SETDT: dt_base = r_vx;
                            cp8_pkg::KK_SETST: st_base = r_vx;
                            cp8_pkg::KK_ADDI:  n_idx = r_idx + {4'b0, r_vx};
                            cp8_pkg::KK_FONT:
                                n_idx = cp8_pkg::CP8_FONT_BASE + (12'(r_vx[3:0]) << 2)
                                        + 12'(r_vx[3:0]);
                            default: n_idx = r_idx;
                        endcase
                    end
                endcase
                // both timers tick once per executed instruction
                n_dt = (dt_base != 8'd0) ? dt_base - 8'd1 : 8'd0;
                n_st = (st_base != 8'd0) ? st_base - 8'd1 : 8'd0;
            end
            cp8_pkg::UOP_LOOP_WR: begin
                if (grp == cp8_pkg::GRP_DRW) begin
                    if ((r_fb[draw_row] & draw_mask) != 64'b0) begin
                        n_hit = 1'b1;
                    end
                    n_fb[draw_row] = r_fb[draw_row] ^ draw_mask;
                    n_v[15] = {7'b0, n_hit};
                end else begin
                    n_v[r_cnt] = r_mem_q;
                end
                n_cnt = r_cnt + 4'd1;
            end
            cp8_pkg::UOP_STORE: n_cnt = r_cnt + 4'd1;
            cp8_pkg::UOP_RESULT: begin
                n_out = {3'b0, r_flt, row_out, r_hit, r_scr, (r_st != 8'd0),
                         r_v[15], r_idx, r_pc};
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= cp8_pkg::CP8_START_RESET;
            r_start    <= cp8_pkg::CP8_START_RESET;
            r_idx      <= '0;
            r_dt       <= '0;
            r_st       <= '0;
            r_sp       <= '0;
            r_cnt      <= '0;
            r_font_cnt <= '0;
            for (int i = 0; i < 16; i++) begin
                r_v[i] <= '0;
            end
            for (int i = 0; i < cp8_pkg::CP8_SCR_H; i++) begin
                r_fb[i] <= '0;
            end
        end else begin
            // the start address register is written but never loads pc; reset loads 0x200
            r_pc       <= n_pc;
            r_idx      <= n_idx;
            r_dt       <= n_dt;
            r_st       <= n_st;
            r_sp       <= n_sp;
            r_cnt      <= n_cnt;
            r_font_cnt <= n_font_cnt;
            r_v        <= n_v;
            r_fb       <= n_fb;
            if (i_cfg_we) begin
                r_start <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_instr <= n_instr;
        r_vx    <= n_vx;
        r_vy    <= n_vy;
        r_stack <= n_stack;
        r_op    <= n_op;
        r_addr  <= n_addr;
        r_data  <= n_data;
        r_row   <= n_row;
        r_keys  <= n_keys;
        r_rnd   <= n_rnd;
        r_scr   <= n_scr;
        r_hit   <= n_hit;
        r_flt   <= n_flt;
        r_out   <= n_out;
    end

endmodule
`default_nettype wire

// File: hdl/chip8_instruction_core.sv
// Top level of the CHIP-8 instruction core: streaming ports, sequencer and
// datapath. Depends on cp8_pkg, cp8_ctrl and cp8_dp.
`timescale 1ns / 1ps
`default_nettype none
// After reset the core copies the hex font into main memory at address 80
// and takes no request meanwhile (configuration writes are taken). Each
// request is one of: load a memory byte, read one framebuffer row, or fetch
// and execute the instruction at pc. An instruction is read from the
// byte-wide 4 KiB memory in two byte fetches, then Vx and Vy pass through
// the single register read port, then it executes. Draws add a read-byte
// and a merge-row step per sprite row, FX65 a read and a write step per
// register, FX55 a store step per register and FX33 one per digit, so the
// longest instruction is FX65 through VF (16 registers). Results leave
// through a one-entry output register; the next request is taken while a
// result waits, but its own result holds until the previous one is taken.
// Both timers tick once per executed instruction. start_address is held for
// software and reset loads pc with 0x200.
module chip8_instruction_core #(
    parameter int STACK_DEPTH = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: address[11:0], data[19:12], row[24:20], keys[40:25],
    //        random_byte[48:41], zero[55:49]
    input  wire [55:0]   i_s_axis_tdata,
    // tuser: op[1:0]
    input  wire [1:0]    i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // tdata: program_counter[11:0], index_value[23:12], flag_register[31:24],
    //        sound_on[32], screen_changed[33], collision[34],
    //        row_pixels[98:35], fault[100:99], zero[103:101]
    output logic [103:0] o_m_axis_tdata,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire [11:0]   i_cfg_data
);

    cp8_pkg::t_cmd    cmd;
    cp8_pkg::t_status status;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    cp8_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_op     (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cp8_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_user  (i_s_axis_tuser),
        .i_in_data  (i_s_axis_tdata),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// File: hdl/cp8_chk.sv
// Port-level checker for chip8_instruction_core and its bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module cp8_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_s_axis_tvalid,
    input wire         o_s_axis_tready,
    input wire         o_m_axis_tvalid,
    input wire         i_m_axis_tready,
    input wire [103:0] o_m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // one request at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while busy");

    // collision only comes from a draw
    a_hit_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[34] |-> o_m_axis_tdata[33])
        else $error("collision without screen change");

    // a stack fault comes only from call or return
    a_fault_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[100:99] != 2'd0 |->
            !o_m_axis_tdata[33] && o_m_axis_tdata[98:35] == 64'd0)
        else $error("fault mixed with draw or row read");

endmodule

bind chip8_instruction_core cp8_chk u_cp8_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for chip8_instruction_core: directed table, then random programs.
// Depends on cp8_pkg and the RTL of the core; needs no files or arguments.
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [4:0]  row;
        logic [15:0] keys;
        logic [7:0]  rnd;
    } t_core_req;

    typedef struct {
        logic [11:0] pc;
        logic [11:0] idx;
        logic [7:0]  flag;
        logic        snd;
        logic        scr;
        logic        col;
        logic [63:0] pix;
        logic [1:0]  flt;
    } t_core_resp;

    typedef struct {
        t_core_req  req;
        bit         typed;
        t_core_resp resp;
    } t_table_row;

    localparam int RET_DEPTH   = 16;
    localparam int PHASE_ITEMS = 200;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    logic         clk;
    logic         rst_n;
    logic         s_valid;
    wire          s_ready;
    logic [55:0]  s_data;
    logic [1:0]   s_user;
    wire          m_valid;
    logic         m_ready;
    wire  [103:0] m_data;
    logic         cfg_valid;
    wire          cfg_ready;
    logic [11:0]  cfg_data;

    chip8_instruction_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Shadow copy of the core's architectural state.
    logic [7:0]  mem_img [4096];
    bit          mem_known [4096];
    logic [7:0]  vreg [16];
    logic [11:0] ret_stack [RET_DEPTH];
    int          ret_depth;
    logic [11:0] pc_q, idx_q;
    logic [7:0]  delay_q, sound_q;
    logic [63:0] screen [32];
    logic [11:0] start_addr_q;

    t_core_resp pending_resp [$];
    int         errors;
    int         mismatches;
    bit         hold_req;
    bit         in_burst, out_burst;

    // Advance the shadow state by one request and return the response it yields.
    task automatic step_core(input t_core_req rq, output t_core_resp rs);
        logic [15:0] w;
        logic [3:0]  x, y, n;
        logic [7:0]  kk, a, b, bits;
        logic [11:0] nnn, ad;
        logic [63:0] mask;
        logic [5:0]  x0;
        logic [4:0]  y0, r;
        bit          hit;
        rs = '{default: '0};
        hit = 0;
        if (rq.op == cp8_pkg::OP_LOAD) begin
            mem_img[rq.addr] = rq.data;
            mem_known[rq.addr] = 1;
        end else if (rq.op == cp8_pkg::OP_READ) begin
            rs.pix = screen[rq.row];
        end else if (rq.op == cp8_pkg::OP_EXEC) begin
            ad = pc_q + 12'd1;
            w = {mem_img[pc_q], mem_img[ad]};
            pc_q = pc_q + 12'd2;
            x = w[11:8]; y = w[7:4]; n = w[3:0]; kk = w[7:0]; nnn = w[11:0];
            a = vreg[x]; b = vreg[y];
            case (w[15:12])
                cp8_pkg::GRP_SYS: begin
                    if (w == cp8_pkg::INS_CLS) begin
                        for (int i = 0; i < 32; i++) screen[i] = '0;
                        rs.scr = 1;
                    end else if (w == cp8_pkg::INS_RET) begin
                        if (ret_depth == 0) rs.flt = cp8_pkg::FLT_UNDER;
                        else begin
                            ret_depth--;
                            pc_q = ret_stack[ret_depth];
                        end
                    end
                end
                cp8_pkg::GRP_JP:   pc_q = nnn;
                cp8_pkg::GRP_CALL: begin
                    if (ret_depth >= RET_DEPTH) rs.flt = cp8_pkg::FLT_OVER;
                    else begin
                        ret_stack[ret_depth] = pc_q;
                        ret_depth++;
                        pc_q = nnn;
                    end
                end
                cp8_pkg::GRP_SE:   if (a == kk) pc_q = pc_q + 12'd2;
                cp8_pkg::GRP_SNE:  if (a != kk) pc_q = pc_q + 12'd2;
                cp8_pkg::GRP_SER:  if (a == b) pc_q = pc_q + 12'd2;
                cp8_pkg::GRP_LDI:  vreg[x] = kk;
                cp8_pkg::GRP_ADDI: vreg[x] = a + kk;
                cp8_pkg::GRP_ALU: begin
                    case (n)
                        cp8_pkg::ALU_MOV:  vreg[x] = b;
                        cp8_pkg::ALU_OR:   vreg[x] = a | b;
                        cp8_pkg::ALU_AND:  vreg[x] = a & b;
                        cp8_pkg::ALU_XOR:  vreg[x] = a ^ b;
                        cp8_pkg::ALU_ADD: begin
                            vreg[x] = a + b;
                            vreg[15] = 8'({1'b0, a} + b > 255);
                        end
                        cp8_pkg::ALU_SUB: begin
                            vreg[x] = a - b;
                            vreg[15] = 8'(a >= b);
                        end
                        cp8_pkg::ALU_SHR: begin
                            vreg[x] = a >> 1;
                            vreg[15] = 8'(a[0]);
                        end
                        cp8_pkg::ALU_SUBN: begin
                            vreg[x] = b - a;
                            vreg[15] = 8'(b >= a);
                        end
                        cp8_pkg::ALU_SHL: begin
                            vreg[x] = a << 1;
                            vreg[15] = 8'(a[7]);
                        end
                        default: ;
                    endcase
                end
                cp8_pkg::GRP_SNER: if (a != b) pc_q = pc_q + 12'd2;
                cp8_pkg::GRP_SETI: idx_q = nnn;
                cp8_pkg::GRP_JPV0: pc_q = nnn + 12'(vreg[0]);
                cp8_pkg::GRP_RND:  vreg[x] = rq.rnd & kk;
                cp8_pkg::GRP_DRW: begin
                    x0 = a[5:0];
                    y0 = b[4:0];
                    for (int i = 0; i < n; i++) begin
                        ad = idx_q + 12'(i);
                        bits = mem_img[ad];
                        mask = '0;
                        for (int j = 0; j < 8; j++)
                            if (bits[7-j]) mask[6'(x0 + j)] = 1'b1;
                        r = 5'(y0 + i);
                        if ((screen[r] & mask) != 0) hit = 1;
                        screen[r] ^= mask;
                    end
                    vreg[15] = hit ? 8'd1 : 8'd0;
                    rs.scr = 1;
                end
                cp8_pkg::GRP_KEY: begin
                    if (kk == cp8_pkg::KK_SKP && rq.keys[a[3:0]])
                        pc_q = pc_q + 12'd2;
                    else if (kk == cp8_pkg::KK_SKNP && !rq.keys[a[3:0]])
                        pc_q = pc_q + 12'd2;
                end
                default: begin
                    case (kk)
                        cp8_pkg::KK_LDDT:  vreg[x] = delay_q;
                        cp8_pkg::KK_SETDT: delay_q = a;
                        cp8_pkg::KK_SETST: sound_q = a;
                        cp8_pkg::KK_ADDI:  idx_q = idx_q + 12'(a);
                        cp8_pkg::KK_FONT:
                            idx_q = cp8_pkg::CP8_FONT_BASE + 12'(a[3:0]) * 12'd5;
                        cp8_pkg::KK_BCD: begin
                            for (int i = 0; i < 3; i++) begin
                                ad = idx_q + 12'(i);
                                mem_known[ad] = 1;
                                mem_img[ad] = (i == 0) ? a / 100 :
                                              (i == 1) ? (a / 10) % 10 : a % 10;
                            end
                        end
                        cp8_pkg::KK_STORE: begin
                            for (int i = 0; i <= x; i++) begin
                                ad = idx_q + 12'(i);
                                mem_img[ad] = vreg[i];
                                mem_known[ad] = 1;
                            end
                        end
                        cp8_pkg::KK_LOAD: begin
                            for (int i = 0; i <= x; i++) begin
                                ad = idx_q + 12'(i);
                                vreg[i] = mem_img[ad];
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
            if (delay_q != 0) delay_q--;
            if (sound_q != 0) sound_q--;
        end
        rs.col  = hit;
        rs.pc   = pc_q;
        rs.idx  = idx_q;
        rs.flag = vreg[15];
        rs.snd  = (sound_q != 0);
    endtask

    // Predict, queue the expected response, then offer the request until taken.
    task automatic send_request(input t_core_req rq, input bit typed,
                                input t_core_resp typed_rs);
        t_core_resp rs;
        int         gap;
        step_core(rq, rs);
        pending_resp.push_back(typed ? typed_rs : rs);
        if (($urandom_range(0, 49)) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge clk);
            s_valid <= 1'b0;
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_user  <= rq.op;
        s_data  <= {7'd0, rq.rnd, rq.keys, rq.row, rq.data, rq.addr};
        do @(posedge clk); while (!(s_valid && s_ready));
    endtask

    task automatic send_load(input logic [11:0] ad, input logic [7:0] d);
        t_core_req rq;
        rq = '{op: cp8_pkg::OP_LOAD, addr: ad, data: d, row: 5'($urandom),
               keys: 16'($urandom), rnd: 8'($urandom)};
        send_request(rq, 0, '{default: '0});
    endtask

    // Fill any never-written bytes in a range so the core never reads them.
    task automatic cover_bytes(input logic [11:0] base, input int count);
        logic [11:0] ad;
        for (int i = 0; i < count; i++) begin
            ad = base + 12'(i);
            if (!mem_known[ad]) send_load(ad, 8'($urandom));
        end
    endtask

    // Build an instruction word; call_bias steers the stack deep.
    function automatic logic [15:0] pick_instr(input bit call_bias);
        logic [15:0] w;
        logic [3:0]  g;
        int          sel;
        w = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (call_bias && sel < 45) g = cp8_pkg::GRP_CALL;
        else if (call_bias && sel < 55) return cp8_pkg::INS_RET;
        else g = 4'($urandom);
        w[15:12] = g;
        case (g)
            cp8_pkg::GRP_SYS: begin
                sel = $urandom_range(0, 3);
                if (sel == 0) w = cp8_pkg::INS_CLS;
                else if (sel == 1) w = cp8_pkg::INS_RET;
            end
            cp8_pkg::GRP_ALU:
                if ($urandom_range(0, 7) != 0)
                    w[3:0] = $urandom_range(0, 8) == 8 ? cp8_pkg::ALU_SHL
                                                       : 4'($urandom_range(0, 7));
            cp8_pkg::GRP_DRW:
                if ($urandom_range(0, 3) == 0) w[3:0] = 4'($urandom_range(0, 2));
            cp8_pkg::GRP_KEY:
                w[7:0] = $urandom_range(0, 1) ? cp8_pkg::KK_SKP : cp8_pkg::KK_SKNP;
            cp8_pkg::GRP_MISC: begin
                case ($urandom_range(0, 10))
                    0: w[7:0] = cp8_pkg::KK_LDDT;
                    1: w[7:0] = cp8_pkg::KK_SETDT;
                    2: w[7:0] = cp8_pkg::KK_SETST;
                    3: w[7:0] = cp8_pkg::KK_ADDI;
                    4: w[7:0] = cp8_pkg::KK_FONT;
                    5: w[7:0] = cp8_pkg::KK_BCD;
                    6: w[7:0] = cp8_pkg::KK_STORE;
                    7: w[7:0] = cp8_pkg::KK_LOAD;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic random_request(input bit call_bias);
        t_core_req   rq;
        logic [15:0] w;
        logic [11:0] pc1;
        int          sel;
        rq = '{op: cp8_pkg::OP_EXEC, addr: 12'($urandom), data: 8'($urandom),
               row: 5'($urandom), keys: 16'($urandom), rnd: 8'($urandom)};
        sel = $urandom_range(0, 99);
        if (sel < 12) rq.op = cp8_pkg::OP_LOAD;
        else if (sel < 22) rq.op = cp8_pkg::OP_READ;
        else if (sel < 25) rq.op = 2'd3;
        if (rq.op == cp8_pkg::OP_EXEC) begin
            pc1 = pc_q + 12'd1;
            if (!mem_known[pc_q] || !mem_known[pc1] || $urandom_range(0, 1)) begin
                w = pick_instr(call_bias);
                send_load(pc_q, w[15:8]);
                send_load(pc1, w[7:0]);
            end
            w = {mem_img[pc_q], mem_img[pc1]};
            if (w[15:12] == cp8_pkg::GRP_DRW)
                cover_bytes(idx_q, w[3:0]);
            else if (w[15:12] == cp8_pkg::GRP_MISC && w[7:0] == cp8_pkg::KK_LOAD)
                cover_bytes(idx_q, w[11:8] + 1);
        end
        send_request(rq, 0, '{default: '0});
    endtask

    // Write the start register; the first write lands while the core still copies the font.
    task automatic write_start(input logic [11:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        start_addr_q = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 0;
                repeat (HOLD_CYCLES) begin
                    @(negedge clk);
                    m_ready <= 1'b0;
                end
            end
            if (($urandom_range(0, 49)) == 0) out_burst = !out_burst;
            gap = out_burst ? 0 : $urandom_range(0, 15);
            repeat (gap) begin
                @(negedge clk);
                m_ready <= 1'b0;
            end
            @(negedge clk);
            m_ready <= 1'b1;
            do @(posedge clk); while (!(m_valid && m_ready));
        end
    end

    // Compare each response with the oldest prediction.
    always @(posedge clk) begin
        t_core_resp e, g;
        if (rst_n && m_valid && m_ready) begin
            g.pc   = m_data[11:0];
            g.idx  = m_data[23:12];
            g.flag = m_data[31:24];
            g.snd  = m_data[32];
            g.scr  = m_data[33];
            g.col  = m_data[34];
            g.pix  = m_data[98:35];
            g.flt  = m_data[100:99];
            if (pending_resp.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected response %p", g);
            end else begin
                e = pending_resp.pop_front();
                if (e != g) begin
                    errors++;
                    if (mismatches++ < 10) $display("mismatch: expected %p, got %p", e, g);
                end
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle = 0;
            else if (++idle >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    t_table_row dir_tbl [$];

    function automatic t_table_row row_of(input logic [1:0] op, input logic [11:0] ad,
                                          input logic [7:0] d, input logic [4:0] r,
                                          input logic [15:0] k, input logic [7:0] rn,
                                          input bit typed, input t_core_resp rs);
        t_table_row t;
        t.req = '{op: op, addr: ad, data: d, row: r, keys: k, rnd: rn};
        t.typed = typed;
        t.resp = rs;
        return t;
    endfunction

    initial begin
        t_core_resp z;
        logic [11:0] cfg_vals [4];
        z = '{default: '0};
        s_valid = 0; s_data = '0; s_user = cp8_pkg::OP_LOAD;
        cfg_valid = 0; cfg_data = '0;
        rst_n = 0; errors = 0; mismatches = 0; hold_req = 0;
        in_burst = 0; out_burst = 0;

        for (int i = 0; i < 4096; i++) begin mem_img[i] = '0; mem_known[i] = 0; end
        for (int i = 0; i < cp8_pkg::CP8_FONT_LEN; i++) begin
            mem_img[cp8_pkg::CP8_FONT_BASE + i] = cp8_pkg::CP8_FONT[i];
            mem_known[cp8_pkg::CP8_FONT_BASE + i] = 1;
        end
        for (int i = 0; i < 16; i++) vreg[i] = '0;
        for (int i = 0; i < 32; i++) screen[i] = '0;
        ret_depth = 0; pc_q = cp8_pkg::CP8_START_RESET; idx_q = '0;
        delay_q = '0; sound_q = '0; start_addr_q = cp8_pkg::CP8_START_RESET;

        // Directed table: reset values, stack underflow, flag extreme, font,
        // draw then redraw for a collision, unused op, address extreme.
        dir_tbl.push_back(row_of(cp8_pkg::OP_READ, 0, 0, 31, 0, 0, 1,
                                 '{12'h200, 0, 0, 0, 0, 0, 0, cp8_pkg::FLT_NONE}));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h200, 8'h00, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h201, 8'hEE, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_EXEC, 0, 0, 0, 0, 0, 1,
                                 '{12'h202, 0, 0, 0, 0, 0, 0, cp8_pkg::FLT_UNDER}));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h202, 8'h6F, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h203, 8'hFF, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_EXEC, 0, 0, 0, 0, 0, 1,
                                 '{12'h204, 0, 8'hFF, 0, 0, 0, 0, cp8_pkg::FLT_NONE}));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h204, 8'hF0, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h205, 8'h29, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_EXEC, 0, 0, 0, 0, 0, 1,
                                 '{12'h206, 12'd80, 8'hFF, 0, 0, 0, 0,
                                   cp8_pkg::FLT_NONE}));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h206, 8'hD0, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h207, 8'h15, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_EXEC, 0, 0, 0, 0, 0, 1,
                                 '{12'h208, 12'd80, 0, 0, 1, 0, 0, cp8_pkg::FLT_NONE}));
        dir_tbl.push_back(row_of(cp8_pkg::OP_READ, 0, 0, 0, 0, 0, 1,
                                 '{12'h208, 12'd80, 0, 0, 0, 0, 64'hF,
                                   cp8_pkg::FLT_NONE}));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h208, 8'hD0, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h209, 8'h15, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_EXEC, 0, 0, 0, 0, 0, 1,
                                 '{12'h20A, 12'd80, 8'd1, 0, 1, 1, 0,
                                   cp8_pkg::FLT_NONE}));
        dir_tbl.push_back(row_of(2'd3, 12'hFFF, 8'hFF, 31, 16'hFFFF, 8'hFF, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'hFFF, 8'hFF, 31, 16'hFFFF, 8'hFF,
                                 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h20A, 8'hC0, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_LOAD, 12'h20B, 8'hFF, 0, 0, 0, 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_EXEC, 12'hFFF, 8'hFF, 31, 16'hFFFF, 8'hFF,
                                 0, z));
        dir_tbl.push_back(row_of(cp8_pkg::OP_READ, 0, 0, 4, 0, 0, 0, z));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The register never loads pc, so no prediction follows it.
        cfg_vals = '{12'hFFF, 12'h000, 12'($urandom), 12'h200};
        write_start(cfg_vals[0]);
        foreach (dir_tbl[i])
            send_request(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].resp);

        for (int ph = 0; ph < 4; ph++) begin
            @(negedge clk);
            s_valid <= 1'b0;
            wait (pending_resp.size() == 0);
            repeat (60) @(posedge clk);
            if (ph > 0) write_start(cfg_vals[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == 100) hold_req = 1;
                random_request((ph % 2) == 1 && (k / 100) % 2 == 0);
            end
        end
        @(negedge clk);
        s_valid <= 1'b0;

        wait (pending_resp.size() == 0);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending_resp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: chip8_instruction_core.f
hdl/cp8_pkg.sv
hdl/cp8_ctrl.sv
hdl/cp8_dp.sv
hdl/chip8_instruction_core.sv
hdl/cp8_chk.sv
bench/tb_top.sv
